/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the CSV tokenizer modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CSVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CSVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/csvt_pkg.sv */
// ---------------------------------------------------------------------------
// CSV tokenizer package
// Word types, parser modes, result kinds and character constants.
// ---------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [2:0] {
    MODE_REC   = 3'd0,
    MODE_FLD   = 3'd1,
    MODE_UNQ   = 3'd2,
    MODE_QUO   = 3'd3,
    MODE_QSEEN = 3'd4,
    MODE_ERR   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FEND = 2'd1,
    KIND_REND = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [31:0] line_count;
    logic        last_result;
  } out_word_t;

  // One queue entry: the main result, optionally preceded by a held-back CR.
  typedef struct packed {
    logic        pre_cr;
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [31:0] line_count;
  } entry_t;

endpackage

/* rtl/csvt_front.sv */
// ---------------------------------------------------------------------------
// CSV tokenizer front end
// Parser state machine: classifies each byte and pushes at most one entry.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csvt_front
  import csvt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_word_t word_i,
  output logic     push_o,
  output entry_t   entry_o
);

  mode_e       mode_q, mode_d;
  logic        pcr_q, pcr_d;
  logic [31:0] lines_q, lines_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_REC;
      pcr_q   <= 1'b0;
      lines_q <= '0;
    end else begin
      mode_q  <= mode_d;
      pcr_q   <= pcr_d;
      lines_q <= lines_d;
    end
  end

  logic [7:0]  c;
  logic [31:0] cur;
  logic        emit, pre_cr, err, live;
  kind_e       kind;
  logic [7:0]  data;

  always_comb begin
    c       = word_i.byte_value;
    cur     = (&lines_q) ? lines_q : lines_q + 32'd1;
    mode_d  = mode_q;
    pcr_d   = pcr_q;
    lines_d = lines_q;
    emit    = 1'b0;
    pre_cr  = 1'b0;
    err     = 1'b0;
    live    = 1'b0;
    kind    = KIND_DATA;
    data    = 8'h00;
    if (accept_i) begin
      if (word_i.end_of_input) begin
        unique case (mode_q) inside
          MODE_QUO: begin
            emit   = 1'b1;
            kind   = KIND_ERR;
            mode_d = MODE_ERR;
            pcr_d  = 1'b0;
          end
          MODE_REC: begin
            pcr_d   = 1'b0;
            lines_d = '0;
          end
          MODE_FLD, MODE_UNQ, MODE_QSEEN: begin
            emit    = 1'b1;
            kind    = KIND_REND;
            mode_d  = MODE_REC;
            pcr_d   = 1'b0;
            lines_d = '0;
          end
          default: ;
        endcase
      end else begin
        unique case (mode_q) inside
          MODE_REC, MODE_FLD: begin
            live = 1'b1;
            if (c == CH_QUOTE) begin
              mode_d = MODE_QUO;
            end else if (c == CH_COMMA) begin
              emit   = 1'b1;
              kind   = KIND_FEND;
              mode_d = MODE_FLD;
            end else if (c == CH_LF) begin
              emit   = 1'b1;
              kind   = KIND_REND;
              mode_d = MODE_REC;
            end else if (c == CH_CR) begin
              pcr_d  = 1'b1;
              mode_d = MODE_UNQ;
            end else begin
              emit   = 1'b1;
              data   = c;
              mode_d = MODE_UNQ;
            end
          end
          MODE_UNQ: begin
            live = 1'b1;
            if (c == CH_CR) begin
              emit  = pcr_q;
              data  = pcr_q ? CH_CR : 8'h00;
              pcr_d = 1'b1;
            end else if (c == CH_LF) begin
              emit   = 1'b1;
              kind   = KIND_REND;
              pcr_d  = 1'b0;
              mode_d = MODE_REC;
            end else begin
              emit   = 1'b1;
              pre_cr = pcr_q;
              pcr_d  = 1'b0;
              if (c == CH_COMMA) begin
                kind   = KIND_FEND;
                mode_d = MODE_FLD;
              end else begin
                data = c;
              end
            end
          end
          MODE_QUO: begin
            live = 1'b1;
            if (c == CH_QUOTE) begin
              mode_d = MODE_QSEEN;
            end else begin
              emit = 1'b1;
              data = c;
            end
          end
          MODE_QSEEN: begin
            live = 1'b1;
            if (pcr_q) begin
              if (c == CH_LF) begin
                emit   = 1'b1;
                kind   = KIND_REND;
                pcr_d  = 1'b0;
                mode_d = MODE_REC;
              end else begin
                err = 1'b1;
              end
            end else if (c == CH_QUOTE) begin
              emit   = 1'b1;
              data   = CH_QUOTE;
              mode_d = MODE_QUO;
            end else if (c == CH_COMMA) begin
              emit   = 1'b1;
              kind   = KIND_FEND;
              mode_d = MODE_FLD;
            end else if (c == CH_LF) begin
              emit   = 1'b1;
              kind   = KIND_REND;
              mode_d = MODE_REC;
            end else if (c == CH_CR) begin
              pcr_d = 1'b1;
            end else begin
              err = 1'b1;
            end
          end
          default: ;
        endcase
        if (err) begin
          emit   = 1'b1;
          pre_cr = 1'b0;
          kind   = KIND_ERR;
          data   = 8'h00;
          mode_d = MODE_ERR;
          pcr_d  = 1'b0;
        end
        if (live && (c == CH_LF) && !(&lines_q)) begin
          lines_d = lines_q + 32'd1;
        end
      end
    end
  end

  assign push_o             = emit;
  assign entry_o.pre_cr     = pre_cr;
  assign entry_o.kind       = kind;
  assign entry_o.data_byte  = data;
  assign entry_o.line_count = cur;

  // Once a format error is seen the parser stays in the error mode.
  `CSVT_ASSERT(a_err_sticky, (mode_q == MODE_ERR) |=> (mode_q == MODE_ERR),
               "error mode left without reset")

endmodule

/* rtl/csvt_fifo.sv */
// ---------------------------------------------------------------------------
// CSV tokenizer entry queue
// Small FIFO that decouples the parser from the output serializer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csvt_fifo
  import csvt_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  `CSVT_ASSERT(a_cnt_bound, cnt_q <= DepthCnt, "queue count beyond depth")

endmodule

/* rtl/csvt_back.sv */
// ---------------------------------------------------------------------------
// CSV tokenizer back end
// Serializes queue entries into output words through an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csvt_back
  import csvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  entry_t    head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic      valid_q, valid_d;
  logic      half_q, half_d;
  out_word_t word_q, word_d;
  logic      load, first_half;

  assign load       = !valid_q || out_ready_i;
  assign first_half = head_i.pre_cr && !half_q;
  assign pop_o      = load && !empty_i && !first_half;

  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    word_d  = word_q;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        word_d.line_count = head_i.line_count;
        if (first_half) begin
          word_d.kind        = KIND_DATA;
          word_d.data_byte   = CH_CR;
          word_d.last_result = 1'b0;
          half_d             = 1'b1;
        end else begin
          word_d.kind        = head_i.kind;
          word_d.data_byte   = head_i.data_byte;
          word_d.last_result = 1'b1;
          half_d             = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = word_q;

  // A word that is not the last of its byte is always the held-back CR.
  `CSVT_ASSERT(a_first_is_cr,
               (valid_q && !word_q.last_result) |->
               (word_q.kind == KIND_DATA && word_q.data_byte == CH_CR),
               "non-final word is not a CR data byte")
  // The second word of a pair follows without a gap.
  `CSVT_ASSERT(a_pair_follows, (valid_q && !word_q.last_result) |=> valid_q,
               "second word of a pair missing")

endmodule

/* rtl/csv_field_tokenizer.sv */
// ---------------------------------------------------------------------------
// CSV field tokenizer
// Path: a byte's result word goes through the entry queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte that releases
// a held CR gives two words, which leave in order, the held CR first.
// Reset (rst_ni low, asynchronous): record start, no held CR, line count 0,
// queue and output register empty.
// ---------------------------------------------------------------------------

module csv_field_tokenizer
  import csvt_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  // The front end is the parser. It decides, in the cycle a byte is
  // accepted, everything the byte causes and packs it into one queue
  // entry: the main result, flagged when a held-back CR must go out first.
  // Bytes that cause nothing push nothing.
  //
  // The queue lets the parser keep taking bytes while the consumer stalls.
  // Input is refused only when the queue is full, so bytes are taken one
  // per cycle until the backlog reaches the queue depth.
  //
  // The back end turns each entry into one or two output words and holds
  // them in the output register until they are taken.

  logic   accept;
  logic   push, pop, full, empty;
  entry_t entry, head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  csvt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_data_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  csvt_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  csvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
